FILE: design/des_ks_pkg.sv
`timescale 1ns / 1ps

package des_ks_pkg;

  localparam int HalfW   = 28;
  localparam int CdW     = 56;
  localparam int KeyW    = 64;
  localparam int SubkeyW = 48;
  localparam int RoundW  = 4;
  localparam int SlotW   = 2;
  localparam int OutDataW = 56;

  localparam logic [RoundW-1:0] LastRound = 4'd15;
  localparam logic [SlotW-1:0]  MiddleSlot = 2'd1;
  localparam logic [SlotW-1:0]  OuterSum   = 2'd2;

  typedef enum logic [1:0] {
    REG_DECRYPT_MODE = 2'd0,
    REG_TRIPLE_MODE  = 2'd1
  } des_ks_reg_t;

  // Control for one round: direction, the unrotated first decrypt round,
  // and a shift of two places rather than one.
  typedef struct packed {
    logic dec;
    logic first;
    logic two;
  } des_ks_rot_t;

  localparam logic [5:0] PC1_TAB [CdW] = '{
    6'd57, 6'd49, 6'd41, 6'd33, 6'd25, 6'd17, 6'd9,  6'd1,
    6'd58, 6'd50, 6'd42, 6'd34, 6'd26, 6'd18, 6'd10, 6'd2,
    6'd59, 6'd51, 6'd43, 6'd35, 6'd27, 6'd19, 6'd11, 6'd3,
    6'd60, 6'd52, 6'd44, 6'd36, 6'd63, 6'd55, 6'd47, 6'd39,
    6'd31, 6'd23, 6'd15, 6'd7,  6'd62, 6'd54, 6'd46, 6'd38,
    6'd30, 6'd22, 6'd14, 6'd6,  6'd61, 6'd53, 6'd45, 6'd37,
    6'd29, 6'd21, 6'd13, 6'd5,  6'd28, 6'd20, 6'd12, 6'd4
  };

  localparam logic [5:0] PC2_TAB [SubkeyW] = '{
    6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,  6'd3,  6'd28,
    6'd15, 6'd6,  6'd21, 6'd10, 6'd23, 6'd19, 6'd12, 6'd4,
    6'd26, 6'd8,  6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
    6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55, 6'd30, 6'd40,
    6'd51, 6'd45, 6'd33, 6'd48, 6'd44, 6'd49, 6'd39, 6'd56,
    6'd34, 6'd53, 6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
  };

  // Bit r is set where round r shifts by two places.
  localparam logic [15:0] SHIFT_TWO = 16'b0111_1110_1111_1100;

  function automatic logic [CdW-1:0] pc1(input logic [KeyW-1:0] key);
    logic [CdW-1:0] r;
    r = '0;
    for (int i = 0; i < CdW; i++) begin
      r[CdW-1-i] = key[KeyW - int'(PC1_TAB[i])];
    end
    return r;
  endfunction

  function automatic logic [SubkeyW-1:0] pc2(input logic [CdW-1:0] cd);
    logic [SubkeyW-1:0] r;
    r = '0;
    for (int j = 0; j < SubkeyW; j++) begin
      r[SubkeyW-1-j] = cd[CdW - int'(PC2_TAB[j])];
    end
    return r;
  endfunction

endpackage

FILE: design/des_ks_round.sv
`timescale 1ns / 1ps

module des_ks_round (
  input  logic [des_ks_pkg::HalfW-1:0]   c,
  input  logic [des_ks_pkg::HalfW-1:0]   d,
  input  des_ks_pkg::des_ks_rot_t        ctrl,
  output logic [des_ks_pkg::HalfW-1:0]   c_rot,
  output logic [des_ks_pkg::HalfW-1:0]   d_rot,
  output logic [des_ks_pkg::SubkeyW-1:0] subkey
);

  function automatic logic [des_ks_pkg::HalfW-1:0] rot(
    input logic [des_ks_pkg::HalfW-1:0] v,
    input des_ks_pkg::des_ks_rot_t      k
  );
    logic [des_ks_pkg::HalfW-1:0] r;
    r = v;
    if (!k.dec) begin
      r = k.two ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
    end else if (!k.first) begin
      r = k.two ? {v[1:0], v[27:2]} : {v[0], v[27:1]};
    end
    return r;
  endfunction

  assign c_rot  = rot(c, ctrl);
  assign d_rot  = rot(d, ctrl);
  assign subkey = des_ks_pkg::pc2({c_rot, d_rot});

endmodule

FILE: design/des_key_schedule.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake             Payload
// in_      slave      in_tvalid/in_tready   tdata key, tuser key_slot
// out_     master     out_tvalid/out_tready tdata subkey+round, tuser out_slot, tlast
// cfg_     slave      cfg_valid/cfg_ready   cfg_index, cfg_data
//
// A key yields sixteen subkeys, one per cycle while the output is not stalled, so a new
// key waits until the last round; the round counter stepping the C and D half registers paces it.
// The next key is taken in the cycle the sixteenth subkey enters the output register.
// A stalled output freezes the round counter; configuration writes are always taken.
// Reset is synchronous and active low and clears the control registers only.

module des_key_schedule (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [des_ks_pkg::KeyW-1:0]        in_tdata,   // key
  input  logic [des_ks_pkg::SlotW-1:0]       in_tuser,   // key_slot
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [des_ks_pkg::OutDataW-1:0]    out_tdata,  // subkey, round, zero fill
  output logic [des_ks_pkg::SlotW-1:0]       out_tuser,  // out_slot
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [1:0]                         cfg_index,
  input  logic                               cfg_data
);

  logic decrypt_mode_r, triple_mode_r;

  logic                              busy_r;
  logic [des_ks_pkg::RoundW-1:0]     round_r;
  logic [des_ks_pkg::HalfW-1:0]      c_r, d_r;
  logic                              dec_r;
  logic [des_ks_pkg::SlotW-1:0]      slot_r;

  logic                              out_valid_r;
  logic [des_ks_pkg::SubkeyW-1:0]    out_subkey_r;
  logic [des_ks_pkg::RoundW-1:0]     out_round_r;
  logic [des_ks_pkg::SlotW-1:0]      out_slot_r;
  logic                              out_last_r;

  logic                              advance, in_xfer, at_last;
  logic                              dec_nxt;
  logic [des_ks_pkg::SlotW-1:0]      slot_nxt;
  logic [des_ks_pkg::CdW-1:0]        cd_nxt;
  des_ks_pkg::des_ks_rot_t           rot_ctrl;
  logic [des_ks_pkg::HalfW-1:0]      c_rot, d_rot;
  logic [des_ks_pkg::SubkeyW-1:0]    subkey;

  assign cfg_ready = 1'b1;

  assign advance   = busy_r && (!out_valid_r || out_tready);
  assign at_last   = (round_r == des_ks_pkg::LastRound);
  assign in_tready = !busy_r || (advance && at_last);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    cd_nxt = des_ks_pkg::pc1(in_tdata);
    if (triple_mode_r) begin
      dec_nxt  = (in_tuser == des_ks_pkg::MiddleSlot) ? !decrypt_mode_r : decrypt_mode_r;
      slot_nxt = decrypt_mode_r ? des_ks_pkg::OuterSum - in_tuser : in_tuser;
    end else begin
      dec_nxt  = decrypt_mode_r;
      slot_nxt = '0;
    end
  end

  assign rot_ctrl.dec   = dec_r;
  assign rot_ctrl.first = (round_r == '0);
  assign rot_ctrl.two   = des_ks_pkg::SHIFT_TWO[round_r];

  des_ks_round u_round (
    .c      (c_r),
    .d      (d_r),
    .ctrl   (rot_ctrl),
    .c_rot  (c_rot),
    .d_rot  (d_rot),
    .subkey (subkey)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decrypt_mode_r <= 1'b0;
      triple_mode_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        des_ks_pkg::REG_DECRYPT_MODE: decrypt_mode_r <= cfg_data;
        des_ks_pkg::REG_TRIPLE_MODE:  triple_mode_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      round_r <= '0;
    end else if (in_xfer) begin
      busy_r  <= 1'b1;
      round_r <= '0;
    end else if (advance) begin
      busy_r  <= !at_last;
      round_r <= round_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      c_r    <= cd_nxt[des_ks_pkg::CdW-1:des_ks_pkg::HalfW];
      d_r    <= cd_nxt[des_ks_pkg::HalfW-1:0];
      dec_r  <= dec_nxt;
      slot_r <= slot_nxt;
    end else if (advance) begin
      c_r <= c_rot;
      d_r <= d_rot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_subkey_r <= subkey;
      out_round_r  <= round_r;
      out_slot_r   <= slot_r;
      out_last_r   <= at_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(des_ks_pkg::OutDataW - des_ks_pkg::SubkeyW - des_ks_pkg::RoundW){1'b0}},
                       out_round_r, out_subkey_r};
  assign out_tuser  = out_slot_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: design/des_ks_checker.sv
`timescale 1ns / 1ps

module des_ks_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [des_ks_pkg::OutDataW-1:0] out_tdata,
  input logic                            out_tlast
);

  logic [des_ks_pkg::RoundW-1:0] round_seen;
  assign round_seen = out_tdata[des_ks_pkg::SubkeyW +: des_ks_pkg::RoundW];

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_last_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> round_seen == des_ks_pkg::LastRound)
    else $error("tlast on a round other than the last");

  a_next_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && round_seen == $past(round_seen) + 1'b1)
    else $error("subkey run broken before its last round");

  a_busy_after_key: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("key taken while a schedule was still starting");

endmodule

bind des_key_schedule des_ks_checker u_des_ks_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
